// ===== hw/rtl/sbbc_pkg.sv =====
// Shared widths, register map, reset values and controller commands for the band-pass conditioner.
`timescale 1ns / 1ps

package sbbc_pkg;

    localparam int RAW_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 17;
    localparam int STATE_W    = 20;
    localparam int CFG_NUM    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = COEF_W + SAMPLE_W;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    localparam int INPUT_GAIN_DEF     = 4;
    localparam int COEF_FRAC_BITS_DEF = 15;
    localparam int NUM_CHANNELS_DEF   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HP_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_A1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_A2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_B0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_B1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_A1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LP_A2 = 3'd7;

    // coefficient slot within one stage's bank
    localparam logic [1:0] COEF_B0 = 2'd0;
    localparam logic [1:0] COEF_B1 = 2'd1;
    localparam logic [1:0] COEF_A1 = 2'd2;
    localparam logic [1:0] COEF_A2 = 2'd3;

    localparam logic signed [COEF_W-1:0] CFG_RESET [CFG_NUM] = '{
        17'sd31874, -17'sd63747, -17'sd63723, 17'sd30999,
        17'sd10396, 17'sd20791, 17'sd2111, 17'sd10010
    };

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL_B0,
        OP_MUL_B1,
        OP_Y,
        OP_MUL_A1,
        OP_MUL_A2,
        OP_UPD,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic lp;
    } t_cmd;

endpackage

// ===== hw/rtl/sbbc_if.sv =====
// Valid/ready stream interfaces for the input and result beats.
`timescale 1ns / 1ps

interface sbbc_in_if import sbbc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RAW_W-1:0] raw_word;
    logic                    right_channel;
    logic                    clear_state;

    modport source (output valid, raw_word, right_channel, clear_state, input ready);
    modport sink (input valid, raw_word, right_channel, clear_state, output ready);
endinterface

interface sbbc_out_if import sbbc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       out_right;

    modport source (output valid, filtered_sample, out_right, input ready);
    modport sink (input valid, filtered_sample, out_right, output ready);
endinterface

// ===== hw/rtl/sbbc_ctrl.sv =====
// Sequencer that steps the shared multiplier through both biquad stages per beat.
`timescale 1ns / 1ps

module sbbc_ctrl import sbbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MB0,
        ST_MB1,
        ST_Y,
        ST_MA1,
        ST_MA2,
        ST_UPD,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_lp;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.lp = r_lp;
        unique case (r_state)
            ST_IDLE: o_cmd.op = i_in_valid ? OP_LOAD : OP_IDLE;
            ST_MB0:  o_cmd.op = OP_MUL_B0;
            ST_MB1:  o_cmd.op = OP_MUL_B1;
            ST_Y:    o_cmd.op = OP_Y;
            ST_MA1:  o_cmd.op = OP_MUL_A1;
            ST_MA2:  o_cmd.op = OP_MUL_A2;
            ST_UPD:  o_cmd.op = OP_UPD;
            ST_DONE: o_cmd.op = slot_free ? OP_EMIT : OP_IDLE;
            default: o_cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lp        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_lp    <= 1'b0;
                        r_state <= ST_MB0;
                    end
                end
                ST_MB0: r_state <= ST_MB1;
                ST_MB1: r_state <= ST_Y;
                ST_Y:   r_state <= ST_MA1;
                ST_MA1: r_state <= ST_MA2;
                ST_MA2: r_state <= ST_UPD;
                ST_UPD: begin
                    if (r_lp) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_lp    <= 1'b1;
                        r_state <= ST_MB0;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/sbbc_datapath.sv =====
// Coefficient registers, per-channel delay state, shared multiplier and accumulators.
`timescale 1ns / 1ps

module sbbc_datapath import sbbc_pkg::*; #(
    parameter int INPUT_GAIN     = INPUT_GAIN_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [RAW_W-1:0]    i_raw_word,
    input  logic                       i_right_channel,
    input  logic                       i_clear_state,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic signed [COEF_W-1:0]   i_cfg_data,
    output logic signed [SAMPLE_W-1:0] o_filtered_sample,
    output logic                       o_out_right
);

    localparam int ACC_W    = STATE_W + COEF_FRAC_BITS + 3;
    localparam int GAIN_W   = $clog2(INPUT_GAIN + 1) + 1;
    localparam int GSCALE_W = SAMPLE_W + GAIN_W;
    localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic signed [ACC_W-1:0]    ACC_MAX = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0]    ACC_MIN = ACC_W'(SAMPLE_MIN);
    localparam logic signed [GSCALE_W-1:0] GS_MAX  = GSCALE_W'(SAMPLE_MAX);
    localparam logic signed [GSCALE_W-1:0] GS_MIN  = GSCALE_W'(SAMPLE_MIN);
    localparam logic signed [GAIN_W-1:0]   GAIN_S  = GAIN_W'(INPUT_GAIN);

    logic signed [COEF_W-1:0]   r_cfg [CFG_NUM];
    logic signed [STATE_W-1:0]  r_z1 [2][NUM_CHANNELS];
    logic signed [STATE_W-1:0]  r_z2 [2][NUM_CHANNELS];
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_y;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   r_b0x;
    logic signed [ACC_W-1:0]    r_acc;
    logic [CH_IDX_W-1:0]        r_idx;
    logic                       r_ch;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                       r_out_right;

    logic [1:0]                 coef_sel;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] opnd;
    logic signed [PROD_W-1:0]   mul;
    logic signed [STATE_W-1:0]  z1_cur;
    logic signed [STATE_W-1:0]  z2_cur;
    logic signed [ACC_W-1:0]    y_sum;
    logic signed [ACC_W-1:0]    y_shr;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    n1_full;
    logic signed [ACC_W-1:0]    n2_full;
    logic signed [GSCALE_W-1:0] scaled;
    logic signed [SAMPLE_W-1:0] scaled_sat;
    logic [CH_IDX_W-1:0]        n_idx;

    always_comb begin
        case (i_cmd.op)
            OP_MUL_B1: coef_sel = COEF_B1;
            OP_MUL_A1: coef_sel = COEF_A1;
            OP_MUL_A2: coef_sel = COEF_A2;
            default:   coef_sel = COEF_B0;
        endcase
    end

    assign coef   = r_cfg[{i_cmd.lp, coef_sel}];
    assign opnd   = (i_cmd.op == OP_MUL_A1 || i_cmd.op == OP_MUL_A2) ? r_y : r_x;
    assign mul    = coef * opnd;
    assign z1_cur = r_z1[i_cmd.lp][r_idx];
    assign z2_cur = r_z2[i_cmd.lp][r_idx];

    // stage output: y = sat16((b0*x + z1 << F) >> F)
    assign y_sum = ACC_W'(r_b0x) + (ACC_W'(z1_cur) <<< COEF_FRAC_BITS);
    assign y_shr = y_sum >>> COEF_FRAC_BITS;
    always_comb begin
        if (y_shr > ACC_MAX) begin
            y_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (y_shr < ACC_MIN) begin
            y_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            y_sat = y_shr[SAMPLE_W-1:0];
        end
    end

    assign acc_next = r_acc - ACC_W'(r_prod) + (ACC_W'(z2_cur) <<< COEF_FRAC_BITS);
    assign n1_full  = r_acc >>> COEF_FRAC_BITS;
    assign n2_full  = (ACC_W'(r_b0x) - ACC_W'(r_prod)) >>> COEF_FRAC_BITS;

    // input scaling: (raw >>> 16) * gain, saturated
    assign scaled = $signed(i_raw_word[RAW_W-1:RAW_W-SAMPLE_W]) * GAIN_S;
    always_comb begin
        if (scaled > GS_MAX) begin
            scaled_sat = SAMPLE_W'(SAMPLE_MAX);
        end else if (scaled < GS_MIN) begin
            scaled_sat = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            scaled_sat = scaled[SAMPLE_W-1:0];
        end
    end

    assign n_idx = (NUM_CHANNELS > 1) ? CH_IDX_W'(i_right_channel) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
            for (int s = 0; s < 2; s++) begin
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    r_z1[s][c] <= '0;
                    r_z2[s][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_addr] <= i_cfg_data;
            end
            case (i_cmd.op)
                OP_LOAD: begin
                    r_x   <= scaled_sat;
                    r_idx <= n_idx;
                    r_ch  <= i_right_channel;
                    if (i_clear_state) begin
                        for (int s = 0; s < 2; s++) begin
                            for (int c = 0; c < NUM_CHANNELS; c++) begin
                                r_z1[s][c] <= '0;
                                r_z2[s][c] <= '0;
                            end
                        end
                    end
                end
                OP_MUL_B0: r_prod <= mul;
                OP_MUL_B1: begin
                    r_b0x  <= r_prod;
                    r_prod <= mul;
                end
                OP_Y: begin
                    r_acc <= ACC_W'(r_prod);
                    r_y   <= y_sat;
                end
                OP_MUL_A1: r_prod <= mul;
                OP_MUL_A2: begin
                    r_acc  <= acc_next;
                    r_prod <= mul;
                end
                OP_UPD: begin
                    r_z1[i_cmd.lp][r_idx] <= n1_full[STATE_W-1:0];
                    r_z2[i_cmd.lp][r_idx] <= n2_full[STATE_W-1:0];
                    r_x                   <= r_y;
                end
                OP_EMIT: begin
                    r_out_sample <= r_y;
                    r_out_right  <= r_ch;
                end
                default: ;
            endcase
        end
    end

    assign o_filtered_sample = r_out_sample;
    assign o_out_right       = r_out_right;

endmodule

// ===== hw/rtl/stereo_biquad_bandpass_conditioner.sv =====
// Top level of the stereo band-pass conditioner: sequencer plus datapath.
`timescale 1ns / 1ps

// Usage:
//   i_in  : input beats (raw_word, right_channel, clear_state), valid/ready.
//   o_out : result beats (filtered_sample, out_right), valid/ready; one per input.
//   i_cfg_we/i_cfg_addr/i_cfg_data : coefficient writes, index 0..7 in the order
//           hp_b0, hp_b1, hp_a1, hp_a2, lp_b0, lp_b1, lp_a1, lp_a2. Write only
//           while no beat is in flight.
// The input is latched at the accepting edge. Each biquad stage takes six
// steps on the single shared 17x16 multiplier (b0*x, b1*x, output, a1*y,
// a2*y, state update), and a final step hands the result to the output
// register. Ready is high only while the sequencer is idle, so a new beat is
// taken only after the previous result has gone to the output register.
// The output register holds one finished result; a stalled receiver delays the
// next result's hand-off, and the block stops accepting input after that.
// Reset loads the default coefficients, zeroes the delay state of every
// channel and empties the output register. clear_state zeroes all channels'
// delay state before the beat that carries it is filtered.
module stereo_biquad_bandpass_conditioner import sbbc_pkg::*; #(
    parameter int INPUT_GAIN     = INPUT_GAIN_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    parameter int NUM_CHANNELS   = NUM_CHANNELS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sbbc_in_if.sink                  i_in,
    sbbc_out_if.source               o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic signed [COEF_W-1:0] i_cfg_data
);

    t_cmd cmd;

    sbbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    sbbc_datapath #(
        .INPUT_GAIN     (INPUT_GAIN),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .NUM_CHANNELS   (NUM_CHANNELS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_raw_word        (i_in.raw_word),
        .i_right_channel   (i_in.right_channel),
        .i_clear_state     (i_in.clear_state),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_data        (i_cfg_data),
        .o_filtered_sample (o_out.filtered_sample),
        .o_out_right       (o_out.out_right)
    );

endmodule

// ===== sim/sbbc_conditioner_checker.sv =====
// Checker for the band-pass conditioner: predicts every result beat and compares it.
`timescale 1ns / 1ps

module sbbc_conditioner_checker import sbbc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    sbbc_in_if                       in_mon,
    sbbc_out_if                      out_mon,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic signed [COEF_W-1:0] i_cfg_data,
    output int                       o_pending,
    output int                       o_errors
);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       right;
    } filtered_beat_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } biquad_coefs_t;

    localparam int LAST_CH   = NUM_CHANNELS_DEF - 1;
    localparam int FRAC      = COEF_FRAC_BITS_DEF;
    localparam int RAW_SHIFT = RAW_W - SAMPLE_W;

    logic signed [COEF_W-1:0]  coef_reg [CFG_NUM];
    logic signed [STATE_W-1:0] hp_z1 [NUM_CHANNELS_DEF];
    logic signed [STATE_W-1:0] hp_z2 [NUM_CHANNELS_DEF];
    logic signed [STATE_W-1:0] lp_z1 [NUM_CHANNELS_DEF];
    logic signed [STATE_W-1:0] lp_z2 [NUM_CHANNELS_DEF];
    filtered_beat_t            expected_beats [$];
    int                        error_count = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        error_count++;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
        if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
        if (v < SAMPLE_MIN) return SAMPLE_W'(SAMPLE_MIN);
        return SAMPLE_W'(v);
    endfunction

    function automatic void clear_delays();
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            hp_z1[i] = '0;
            hp_z2[i] = '0;
            lp_z1[i] = '0;
            lp_z2[i] = '0;
        end
    endfunction

    // transposed direct form II, symmetric numerator, delays wrap to STATE_W bits
    function automatic logic signed [SAMPLE_W-1:0] biquad_df2t(
        input  biquad_coefs_t              c,
        input  logic signed [SAMPLE_W-1:0] x,
        inout  logic signed [STATE_W-1:0]  z1,
        inout  logic signed [STATE_W-1:0]  z2
    );
        longint                     b0x;
        longint                     n1;
        longint                     n2;
        logic signed [SAMPLE_W-1:0] y;
        b0x = longint'($signed(c.b0)) * longint'(x);
        y   = clip16((b0x + (longint'(z1) <<< FRAC)) >>> FRAC);
        n1  = (longint'($signed(c.b1)) * longint'(x) - longint'($signed(c.a1)) * longint'(y)
               + (longint'(z2) <<< FRAC)) >>> FRAC;
        n2  = (b0x - longint'($signed(c.a2)) * longint'(y)) >>> FRAC;
        z1  = n1[STATE_W-1:0];
        z2  = n2[STATE_W-1:0];
        return y;
    endfunction

    function automatic filtered_beat_t condition_sample(
        input logic [RAW_W-1:0] raw,
        input logic             right,
        input logic             clr
    );
        int                         ch;
        biquad_coefs_t              hp;
        biquad_coefs_t              lp;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [STATE_W-1:0]  z1;
        logic signed [STATE_W-1:0]  z2;
        filtered_beat_t             beat;
        ch = (int'(right) < NUM_CHANNELS_DEF) ? int'(right) : LAST_CH;
        if (clr) clear_delays();
        hp = '{b0: coef_reg[CFG_HP_B0], b1: coef_reg[CFG_HP_B1],
               a1: coef_reg[CFG_HP_A1], a2: coef_reg[CFG_HP_A2]};
        lp = '{b0: coef_reg[CFG_LP_B0], b1: coef_reg[CFG_LP_B1],
               a1: coef_reg[CFG_LP_A1], a2: coef_reg[CFG_LP_A2]};
        x = clip16((longint'($signed(raw)) >>> RAW_SHIFT) * INPUT_GAIN_DEF);
        z1 = hp_z1[ch];
        z2 = hp_z2[ch];
        y = biquad_df2t(hp, x, z1, z2);
        hp_z1[ch] = z1;
        hp_z2[ch] = z2;
        z1 = lp_z1[ch];
        z2 = lp_z2[ch];
        y = biquad_df2t(lp, y, z1, z2);
        lp_z1[ch] = z1;
        lp_z2[ch] = z2;
        beat.sample = y;
        beat.right  = right;
        return beat;
    endfunction

    always @(posedge i_clk) begin
        filtered_beat_t got;
        filtered_beat_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_NUM; i++) coef_reg[i] = CFG_RESET[i];
            clear_delays();
            expected_beats.delete();
        end else begin
            // result side first: a beat leaving now belongs to an older input
            if (out_mon.valid && out_mon.ready) begin
                got.sample = out_mon.filtered_sample;
                got.right  = out_mon.out_right;
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected: %0d ch %0b",
                                              got.sample, got.right));
                end else begin
                    want = expected_beats.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch($sformatf("filtered_sample %0d, expected %0d",
                                                  got.sample, want.sample));
                    if (got.right !== want.right)
                        report_mismatch($sformatf("out_right %0b, expected %0b",
                                                  got.right, want.right));
                end
            end
            if (in_mon.valid && in_mon.ready)
                expected_beats.push_back(condition_sample(in_mon.raw_word,
                                                          in_mon.right_channel,
                                                          in_mon.clear_state));
            if (i_cfg_we) coef_reg[i_cfg_addr] = i_cfg_data;
        end
        o_pending <= expected_beats.size();
        o_errors  <= error_count;
    end

endmodule

// ===== sim/tb_stereo_biquad_bandpass_conditioner.sv =====
// Testbench top for the band-pass conditioner: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_stereo_biquad_bandpass_conditioner;
    import sbbc_pkg::*;

    typedef enum int {
        SET_DEFAULT,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_CORNERS,
        SET_RANDOM,
        SET_NEAR_DEFAULT
    } coef_set_t;

    localparam int     NUM_PHASES      = 6;
    localparam int     ITEMS_PER_PHASE = 325;
    localparam int     LATENCY_PAUSE   = 16;
    localparam int     END_PAUSE       = 40;
    localparam longint CYCLE_LIMIT     = 500000;
    localparam logic   CH_LEFT         = 1'b0;
    localparam logic   CH_RIGHT        = 1'b1;
    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_addr = '0;
    logic signed [COEF_W-1:0] i_cfg_data = '0;
    logic                     out_ready  = 1'b0;
    logic                     idle_on    = 1'b1;
    logic                     next_ch    = CH_LEFT;
    int                       stall_left = 0;
    longint                   cycle_count = 0;
    int                       pending;
    int                       errors;
    logic signed [COEF_W-1:0] coef_plan [CFG_NUM];

    sbbc_in_if  in_bus ();
    sbbc_out_if out_bus ();

    assign out_bus.ready = out_ready;

    stereo_biquad_bandpass_conditioner DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    sbbc_conditioner_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_mon     (in_bus),
        .out_mon    (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_stereo_biquad_bandpass_conditioner: errors");
            $finish;
        end
    end

    // receiver starts random stall bursts only while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 6);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_beat(input logic [RAW_W-1:0] raw, input logic ch, input logic clr);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.raw_word      <= raw;
        in_bus.right_channel <= ch;
        in_bus.clear_state   <= clr;
        do @(posedge i_clk); while (!in_bus.ready);
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (LATENCY_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_coef_plan();
        for (int i = 0; i < CFG_NUM; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= CFG_IDX_W'(i);
            i_cfg_data <= coef_plan[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] pick_raw_word();
        logic [RAW_W-1:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2: w = $urandom();
            3, 4, 5, 6: w = {16'(int'($urandom_range(0, 8191)) - 4096), 16'($urandom())};
            // around the point where the input gain saturates
            7: w = {16'(int'($urandom_range(0, 64)) - 32 + ($urandom_range(0, 1) ? 8192 : -8192)),
                    16'($urandom())};
            8: w = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: w = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom())};
        endcase
        return w;
    endfunction

    initial begin
        coef_set_t cs;
        logic      ch;
        logic      clr;
        in_bus.valid         <= 1'b0;
        in_bus.raw_word      <= '0;
        in_bus.right_channel <= CH_LEFT;
        in_bus.clear_state   <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed beats on reset coefficients
        send_beat(32'h0000_0000, CH_LEFT,  1'b1);
        send_beat(32'h0000_0000, CH_RIGHT, 1'b0);
        send_beat(32'h7FFF_FFFF, CH_LEFT,  1'b0);
        send_beat(32'h8000_0000, CH_RIGHT, 1'b0);
        send_beat(32'h7FFF_FFFF, CH_LEFT,  1'b0);
        send_beat(32'h8000_0000, CH_RIGHT, 1'b0);
        send_beat(32'h0001_0000, CH_LEFT,  1'b0);
        send_beat(32'hFFFF_0000, CH_RIGHT, 1'b0);
        send_beat(32'h1FFF_FFFF, CH_LEFT,  1'b0);
        send_beat(32'h2000_0000, CH_RIGHT, 1'b0);
        send_beat(32'hE000_0000, CH_LEFT,  1'b0);
        send_beat(32'hDFFF_FFFF, CH_RIGHT, 1'b0);
        send_beat(32'h0000_FFFF, CH_LEFT,  1'b0);
        send_beat(32'hFFFF_FFFF, CH_RIGHT, 1'b0);
        send_beat(32'h1234_5678, CH_LEFT,  1'b1);
        send_beat(32'h8000_0000, CH_LEFT,  1'b0);
        send_beat(32'h8000_0000, CH_LEFT,  1'b0);
        send_beat(32'h8000_0000, CH_LEFT,  1'b0);
        send_beat(32'h7FFF_FFFF, CH_RIGHT, 1'b0);
        send_beat(32'h7FFF_FFFF, CH_RIGHT, 1'b0);
        send_beat(32'h7FFF_FFFF, CH_RIGHT, 1'b1);
        send_beat(32'h5555_AAAA, CH_LEFT,  1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            cs = coef_set_t'(p);
            idle_on = (cs != SET_ALL_MIN) && (p != NUM_PHASES - 1);
            for (int i = 0; i < CFG_NUM; i++) begin
                case (cs)
                    SET_DEFAULT:  coef_plan[i] = CFG_RESET[i];
                    SET_ALL_MAX:  coef_plan[i] = COEF_MAX;
                    SET_ALL_MIN:  coef_plan[i] = COEF_MIN;
                    SET_CORNERS: begin
                        case ($urandom_range(0, 4))
                            0:       coef_plan[i] = COEF_MAX;
                            1:       coef_plan[i] = COEF_MIN;
                            2:       coef_plan[i] = '0;
                            3:       coef_plan[i] = 17'sd1;
                            default: coef_plan[i] = -17'sd1;
                        endcase
                    end
                    SET_RANDOM:   coef_plan[i] = COEF_W'($urandom());
                    default:      coef_plan[i] = CFG_RESET[i] +
                                                 COEF_W'(int'($urandom_range(0, 4095)) - 2048);
                endcase
            end
            write_coef_plan();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // mostly alternating left/right frames, sometimes out of order
                if ($urandom_range(0, 9) == 0) ch = 1'($urandom_range(0, 1));
                else ch = next_ch;
                next_ch = ~ch;
                clr = (n == 0) || ($urandom_range(0, 59) == 0);
                send_beat(pick_raw_word(), ch, clr);
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (END_PAUSE) @(posedge i_clk);
        if (errors == 0)
            $display("tb_stereo_biquad_bandpass_conditioner: clean");
        else
            $display("tb_stereo_biquad_bandpass_conditioner: errors");
        $finish;
    end

endmodule
